[rtl/cpjv_pkg.sv]
// ============================================================================
// cpjv_pkg
// Types, constants and fixed-point helpers for the cascaded joint PID block.
// ============================================================================
package cpjv_pkg;

    // Data word and wide intermediate widths
    localparam int DW        = 32;
    localparam int WIDE      = 66;
    localparam int DT_W      = 22;
    localparam int LIM_W     = 31;
    localparam int PROD_W    = 2 * DW;
    localparam int QUO_W     = DW + 24;
    localparam int CNT_W     = 6;
    localparam int MUL_STEPS = DW;
    localparam int DIV_STEPS = QUO_W;
    localparam int GAINS     = 6;

    // Control period clamp, Q0.24
    localparam logic [DT_W-1:0] DT_MIN = 22'd1678;
    localparam logic [DT_W-1:0] DT_MAX = 22'd3355443;

    // Item function codes
    localparam logic [1:0] FUNC_STEP  = 2'd0;
    localparam logic [1:0] FUNC_GAIN  = 2'd1;
    localparam logic [1:0] FUNC_RST   = 2'd2;
    localparam logic [1:0] FUNC_RSTALL = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_STEP_TIME = 3'd0;
    localparam logic [2:0] REG_OI_LIM    = 3'd1;
    localparam logic [2:0] REG_II_LIM    = 3'd2;
    localparam logic [2:0] REG_OV_LIM    = 3'd3;
    localparam logic [2:0] REG_CV_LIM    = 3'd4;
    localparam logic [2:0] REG_CA_LIM    = 3'd5;

    // Gain slots within a joint
    localparam logic [2:0] G_OKP = 3'd0;
    localparam logic [2:0] G_OKI = 3'd1;
    localparam logic [2:0] G_OKD = 3'd2;
    localparam logic [2:0] G_IKP = 3'd3;
    localparam logic [2:0] G_IKI = 3'd4;
    localparam logic [2:0] G_IKD = 3'd5;

    // Sequencer states
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_FETCH = 8'b0000_0010,
        ST_SETUP = 8'b0000_0100,
        ST_PREP  = 8'b0000_1000,
        ST_MUL   = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_FIX   = 8'b0100_0000,
        ST_POST  = 8'b1000_0000
    } state_t;

    // Step sequence, one operation of the shared units each
    typedef enum logic [10:0] {
        P_OI  = 11'b000_0000_0001,  // pe * dt          -> outer integral
        P_OD  = 11'b000_0000_0010,  // dpe / dt         -> outer derivative
        P_OP  = 11'b000_0000_0100,  // kp * pe
        P_OIG = 11'b000_0000_1000,  // ki * integral
        P_ODG = 11'b000_0001_0000,  // kd * derivative  -> vref
        P_II  = 11'b000_0010_0000,  // ve * dt          -> inner integral
        P_ID  = 11'b000_0100_0000,  // dve / dt         -> inner derivative
        P_IP  = 11'b000_1000_0000,
        P_IIG = 11'b001_0000_0000,
        P_IDG = 11'b010_0000_0000,  //                  -> raw command
        P_ACC = 11'b100_0000_0000   // accel * dt       -> rate limit
    } phase_t;

    // Saturate a wide signed value to one data word
    function automatic logic signed [DW-1:0] sat_dw(input logic signed [WIDE-1:0] v);
        logic [WIDE-DW:0] top;
        top = v[WIDE-1:DW-1];
        if ((&top) || !(|top))
            return v[DW-1:0];
        else if (v[WIDE-1])
            return {1'b1, {(DW-1){1'b0}}};
        else
            return {1'b0, {(DW-1){1'b1}}};
    endfunction

    // Clamp a wide signed value to +/- lim
    function automatic logic signed [DW-1:0] clamp_mag(input logic signed [WIDE-1:0] v,
                                                      input logic [LIM_W-1:0] lim);
        logic signed [WIDE-1:0] ls;
        ls = $signed({{(WIDE-LIM_W){1'b0}}, lim});
        if (v > ls)
            return ls[DW-1:0];
        else if (v < -ls)
            return DW'(-ls);
        else
            return v[DW-1:0];
    endfunction

    // Magnitude of a signed word (fits unsigned, also for the most negative)
    function automatic logic [DW-1:0] mag_dw(input logic signed [DW-1:0] v);
        return v[DW-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

[rtl/cascade_pid_joint_velocity.sv]
// ============================================================================
// cascade_pid_joint_velocity
// Per-joint cascaded position/velocity PID, Q16.16, with rate-limited output.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) carries one item per beat: a control
//   step, a gain load, a joint reset or an all-joint reset. Only a control
//   step for a joint below JOINTS returns a beat on the output channel
//   (out_valid/out_ready) with the joint and the velocity command.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data;
//   the user writes them only while the block is idle; the block does not enforce it.
//   A control step runs nine products on a bit-serial shift-add multiplier
//   and two derivative quotients on a bit-serial restoring divider. No new
//   item is accepted until the step is through; gain loads and resets
//   complete on acceptance and in_ready stays high.
//   The result sits in an output register, so the next item is accepted
//   while it waits; a following step holds in its last phase until the
//   receiver takes the earlier beat.
//   Reset clears all joint state, gains and configuration to defaults.
// ============================================================================
module cascade_pid_joint_velocity
    import cpjv_pkg::*;
#(
    parameter int JOINTS = 16
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [LIM_W-1:0]      cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            func,
    input  logic [3:0]            joint,
    input  logic signed [DW-1:0]  position_ref,
    input  logic signed [DW-1:0]  velocity_ref,
    input  logic signed [DW-1:0]  position_meas,
    input  logic signed [DW-1:0]  velocity_meas,
    input  logic [2:0]            gain_select,
    input  logic signed [DW-1:0]  gain_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [3:0]            joint_out,
    output logic signed [DW-1:0]  cmd_vel
);

    localparam int JW     = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int GDEPTH = JOINTS * GAINS;
    localparam int GW     = $clog2(GDEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DT_W-1:0]  step_time_reg;
    logic [LIM_W-1:0] oi_lim_reg, ii_lim_reg, ov_lim_reg, cv_lim_reg, ca_lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_time_reg <= 22'd16777;
            oi_lim_reg    <= 31'd65536;
            ii_lim_reg    <= 31'd65536;
            ov_lim_reg    <= 31'd65536;
            cv_lim_reg    <= 31'd65536;
            ca_lim_reg    <= 31'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STEP_TIME: step_time_reg <= cfg_data[DT_W-1:0];
                REG_OI_LIM:    oi_lim_reg    <= cfg_data;
                REG_II_LIM:    ii_lim_reg    <= cfg_data;
                REG_OV_LIM:    ov_lim_reg    <= cfg_data;
                REG_CV_LIM:    cv_lim_reg    <= cfg_data;
                REG_CA_LIM:    ca_lim_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamped control period
    logic [DT_W-1:0] dt;
    always_comb
    begin
        if (step_time_reg < DT_MIN)
            dt = DT_MIN;
        else if (step_time_reg > DT_MAX)
            dt = DT_MAX;
        else
            dt = step_time_reg;
    end

    // ------------------------------------------------------------------
    // Sequencer and handshake decode
    // ------------------------------------------------------------------
    state_t state_reg;
    phase_t phase_reg;
    logic   out_valid_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic          in_acc, joint_ok, is_div, deliver;
    logic [JW-1:0] jin;
    logic [JW-1:0] jidx_reg;
    logic [3:0]    joint_reg;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign joint_ok = ({28'd0, joint} < 32'(JOINTS));
    assign jin      = JW'(joint);
    assign is_div   = (phase_reg == P_OD) || (phase_reg == P_ID);
    assign deliver  = (state_reg == ST_POST) && (phase_reg == P_ACC)
                      && (!out_valid_reg || out_ready);

    function automatic phase_t next_phase(input phase_t p);
        case (p)
            P_OI:    return P_OD;
            P_OD:    return P_OP;
            P_OP:    return P_OIG;
            P_OIG:   return P_ODG;
            P_ODG:   return P_II;
            P_II:    return P_ID;
            P_ID:    return P_IP;
            P_IP:    return P_IIG;
            P_IIG:   return P_IDG;
            P_IDG:   return P_ACC;
            default: return P_OI;
        endcase
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= P_OI;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && func == FUNC_STEP && joint_ok)
                    begin
                        state_reg <= ST_FETCH;
                        phase_reg <= P_OI;
                    end
                end
                ST_FETCH: state_reg <= ST_SETUP;
                ST_SETUP: state_reg <= ST_PREP;
                ST_PREP:
                begin
                    state_reg <= is_div ? ST_DIV : ST_MUL;
                    cnt_reg   <= is_div ? CNT_W'(DIV_STEPS) : CNT_W'(MUL_STEPS);
                end
                ST_MUL, ST_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                        state_reg <= ST_FIX;
                end
                ST_FIX: state_reg <= ST_POST;
                ST_POST:
                begin
                    if (phase_reg != P_ACC)
                    begin
                        phase_reg <= next_phase(phase_reg);
                        state_reg <= ST_FETCH;
                    end
                    else if (deliver)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Gain memory with per-entry valid bits (zero until loaded)
    // ------------------------------------------------------------------
    logic signed [DW-1:0] gain_mem [GDEPTH];
    logic [GDEPTH-1:0]    gain_vld_reg;
    logic signed [DW-1:0] gain_rd_reg;
    logic [2:0]           gidx;
    logic [GW-1:0]        gaddr, gwaddr;
    logic                 gain_wr;

    always_comb
    begin
        case (phase_reg)
            P_OP:    gidx = G_OKP;
            P_OIG:   gidx = G_OKI;
            P_ODG:   gidx = G_OKD;
            P_IP:    gidx = G_IKP;
            P_IIG:   gidx = G_IKI;
            P_IDG:   gidx = G_IKD;
            default: gidx = G_OKP;
        endcase
    end

    assign gaddr   = GW'(32'(jidx_reg) * GAINS + 32'(gidx));
    assign gwaddr  = GW'(32'(jin) * GAINS + 32'(gain_select));
    assign gain_wr = in_acc && func == FUNC_GAIN && joint_ok
                     && (gain_select < 3'(GAINS));

    always_ff @(posedge clk)
    begin
        if (gain_wr)
            gain_mem[gwaddr] <= gain_value;
    end

    always_ff @(posedge clk)
    begin
        gain_rd_reg <= gain_vld_reg[gaddr] ? gain_mem[gaddr] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_vld_reg <= '0;
        else if (gain_wr)
            gain_vld_reg[gwaddr] <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Per-joint dynamic state
    // ------------------------------------------------------------------
    logic signed [DW-1:0] oi_mem  [JOINTS];
    logic signed [DW-1:0] ii_mem  [JOINTS];
    logic signed [DW-1:0] lpe_mem [JOINTS];
    logic signed [DW-1:0] lve_mem [JOINTS];
    logic signed [DW-1:0] lc_mem  [JOINTS];

    logic signed [DW-1:0] pe_reg, ve_reg, oi_reg, ii_reg, lpe_reg, lve_reg, lc_reg;
    logic signed [DW-1:0] vr_reg, vm_reg, d_reg, vref_reg, cmd_reg;
    logic signed [WIDE-1:0] sum_reg;
    logic signed [DW-1:0] cmd_final;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < JOINTS; k++)
            begin
                oi_mem[k]  <= '0;
                ii_mem[k]  <= '0;
                lpe_mem[k] <= '0;
                lve_mem[k] <= '0;
                lc_mem[k]  <= '0;
            end
        end
        else if (in_acc && func == FUNC_RSTALL)
        begin
            for (int k = 0; k < JOINTS; k++)
            begin
                oi_mem[k]  <= '0;
                ii_mem[k]  <= '0;
                lpe_mem[k] <= '0;
                lve_mem[k] <= '0;
                lc_mem[k]  <= '0;
            end
        end
        else if (in_acc && func == FUNC_RST && joint_ok)
        begin
            oi_mem[jin]  <= '0;
            ii_mem[jin]  <= '0;
            lpe_mem[jin] <= '0;
            lve_mem[jin] <= '0;
            lc_mem[jin]  <= '0;
        end
        else if (deliver)
        begin
            oi_mem[jidx_reg]  <= oi_reg;
            ii_mem[jidx_reg]  <= ii_reg;
            lpe_mem[jidx_reg] <= pe_reg;
            lve_mem[jidx_reg] <= ve_reg;
            lc_mem[jidx_reg]  <= cmd_final;
        end
    end

    // ------------------------------------------------------------------
    // Operand selection for the shared units
    // ------------------------------------------------------------------
    logic signed [DW-1:0] ve_new, diff_o, diff_i, dt_s, opa_sel, opb_sel;

    assign ve_new = sat_dw(WIDE'(vref_reg) - WIDE'(vm_reg));
    assign diff_o = sat_dw(WIDE'(pe_reg) - WIDE'(lpe_reg));
    assign diff_i = sat_dw(WIDE'(ve_reg) - WIDE'(lve_reg));
    assign dt_s   = $signed({{(DW-DT_W){1'b0}}, dt});

    always_comb
    begin
        opa_sel = gain_rd_reg;
        opb_sel = dt_s;
        case (phase_reg)
            P_OI:    opa_sel = pe_reg;
            P_OD:    opa_sel = diff_o;
            P_OP:    opb_sel = pe_reg;
            P_OIG:   opb_sel = oi_reg;
            P_ODG:   opb_sel = d_reg;
            P_II:    opa_sel = ve_new;
            P_ID:    opa_sel = diff_i;
            P_IP:    opb_sel = ve_reg;
            P_IIG:   opb_sel = ii_reg;
            P_IDG:   opb_sel = d_reg;
            P_ACC:   opa_sel = $signed({1'b0, ca_lim_reg});
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Bit-serial multiplier and divider datapath
    // ------------------------------------------------------------------
    logic signed [DW-1:0]   opa_reg, opb_reg, mres_reg, dres_reg;
    logic [DW-1:0]          amag_reg, bsh_reg;
    logic [PROD_W-1:0]      acc_reg;
    logic [QUO_W-1:0]       qsh_reg;
    logic [DT_W-1:0]        rem_reg;
    logic                   msign_reg, sh24_reg;

    logic [DW:0]            mul_sum;
    logic [DT_W:0]          rem_sh;
    logic signed [WIDE-1:0] mval, mrnd, qval;

    assign mul_sum = {1'b0, acc_reg[PROD_W-1:DW]} + (bsh_reg[0] ? {1'b0, amag_reg} : '0);
    assign rem_sh  = {rem_reg, qsh_reg[QUO_W-1]};

    always_comb
    begin
        mval = $signed({{(WIDE-PROD_W){1'b0}}, acc_reg});
        mrnd = sh24_reg ? WIDE'(66'sd8388608) : WIDE'(66'sd32768);
        mrnd = msign_reg ? (mrnd - mval) : (mrnd + mval);
        mrnd = sh24_reg ? (mrnd >>> 24) : (mrnd >>> 16);
        qval = $signed({{(WIDE-QUO_W){1'b0}}, qsh_reg});
        qval = msign_reg ? -qval : qval;
    end

    // post-step arithmetic
    logic signed [DW-1:0] delta;
    assign delta     = clamp_mag(WIDE'(cmd_reg) - WIDE'(lc_reg), mres_reg[LIM_W-1:0]);
    assign cmd_final = clamp_mag(WIDE'(lc_reg) + WIDE'(delta), cv_lim_reg);

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    jidx_reg  <= jin;
                    joint_reg <= joint;
                    pe_reg    <= sat_dw(WIDE'(position_ref) - WIDE'(position_meas));
                    vr_reg    <= velocity_ref;
                    vm_reg    <= velocity_meas;
                    if (joint_ok)
                    begin
                        oi_reg  <= oi_mem[jin];
                        ii_reg  <= ii_mem[jin];
                        lpe_reg <= lpe_mem[jin];
                        lve_reg <= lve_mem[jin];
                        lc_reg  <= lc_mem[jin];
                    end
                end
            end
            ST_SETUP:
            begin
                opa_reg  <= opa_sel;
                opb_reg  <= opb_sel;
                sh24_reg <= (phase_reg == P_OI) || (phase_reg == P_II)
                            || (phase_reg == P_ACC);
                if (phase_reg == P_II)
                    ve_reg <= ve_new;
            end
            ST_PREP:
            begin
                amag_reg  <= mag_dw(opa_reg);
                bsh_reg   <= mag_dw(opb_reg);
                acc_reg   <= '0;
                rem_reg   <= '0;
                qsh_reg   <= {mag_dw(opa_reg), 24'd0};
                msign_reg <= is_div ? opa_reg[DW-1] : (opa_reg[DW-1] ^ opb_reg[DW-1]);
            end
            ST_MUL:
            begin
                // one multiplier bit per cycle, LSB first
                acc_reg <= {mul_sum, acc_reg[DW-1:1]};
                bsh_reg <= {1'b0, bsh_reg[DW-1:1]};
            end
            ST_DIV:
            begin
                // one quotient bit per cycle, restoring
                if (rem_sh >= {1'b0, dt})
                begin
                    rem_reg <= DT_W'(rem_sh - {1'b0, dt});
                    qsh_reg <= {qsh_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[DT_W-1:0];
                    qsh_reg <= {qsh_reg[QUO_W-2:0], 1'b0};
                end
            end
            ST_FIX:
            begin
                if (is_div)
                    dres_reg <= sat_dw(qval);
                else
                    mres_reg <= sat_dw(mrnd);
            end
            ST_POST:
            begin
                case (phase_reg)
                    P_OI:  oi_reg   <= clamp_mag(WIDE'(oi_reg) + WIDE'(mres_reg), oi_lim_reg);
                    P_OD:  d_reg    <= dres_reg;
                    P_OP:  sum_reg  <= WIDE'(vr_reg) + WIDE'(mres_reg);
                    P_OIG: sum_reg  <= sum_reg + WIDE'(mres_reg);
                    P_ODG: vref_reg <= clamp_mag(sum_reg + WIDE'(mres_reg), ov_lim_reg);
                    P_II:  ii_reg   <= clamp_mag(WIDE'(ii_reg) + WIDE'(mres_reg), ii_lim_reg);
                    P_ID:  d_reg    <= dres_reg;
                    P_IP:  sum_reg  <= WIDE'(vref_reg) + WIDE'(mres_reg);
                    P_IIG: sum_reg  <= sum_reg + WIDE'(mres_reg);
                    P_IDG: cmd_reg  <= sat_dw(sum_reg + WIDE'(mres_reg));
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [3:0]           joint_out_reg;
    logic signed [DW-1:0] cmd_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (deliver)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (deliver)
        begin
            joint_out_reg <= joint_reg;
            cmd_out_reg   <= cmd_final;
        end
    end

    assign out_valid = out_valid_reg;
    assign joint_out = joint_out_reg;
    assign cmd_vel   = cmd_out_reg;

endmodule

[rtl/cpjv_checker.sv]
// ============================================================================
// cpjv_checker
// Port-level assertions for the cascaded joint PID block.
// ============================================================================
module cpjv_checker
    import cpjv_pkg::*;
#(
    parameter int JOINTS = 16
)(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic [1:0]           func,
    input logic [3:0]           joint,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [3:0]           joint_out,
    input logic signed [DW-1:0] cmd_vel
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cmd_vel) && $stable(joint_out))
        else $error("result beat changed while stalled");

    // no result during reset
    a_rst_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // a control step occupies the block
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && func == FUNC_STEP && ({28'd0, joint} < 32'(JOINTS))
        |=> !in_ready)
        else $error("step accepted but block still ready");

    // other items do not stall the input
    a_cmd_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && func != FUNC_STEP |=> in_ready)
        else $error("non-step item stalled the input");

    // magnitude clamp never yields the most negative word
    a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cmd_vel != {1'b1, {(DW-1){1'b0}}})
        else $error("command outside magnitude clamp");

endmodule

bind cascade_pid_joint_velocity cpjv_checker #(.JOINTS(JOINTS)) u_cpjv_checker (.*);

[test/tb.sv]
// ============================================================================
// tb
// Self-checking bench for cascade_pid_joint_velocity. Beats are sent on the
// input channel and each accepted control step is run through a cycle-free
// copy of the cascaded PID arithmetic. The expected commands are queued and
// checked in order against the output channel. Both sides idle at random.
// The receiver also holds off for long stretches.
// ============================================================================
module tb;
    import cpjv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NJ          = 16;
    localparam int STALL_LIMIT = 8000;
    localparam int HOLD_CYCLES = 1500;
    localparam int SETTLE      = 30;

    typedef struct {
        logic [1:0]           func;
        logic [3:0]           joint;
        logic signed [DW-1:0] pos_ref;
        logic signed [DW-1:0] vel_ref;
        logic signed [DW-1:0] pos_meas;
        logic signed [DW-1:0] vel_meas;
        logic [2:0]           gsel;
        logic signed [DW-1:0] gval;
    } beat_t;

    typedef struct {
        logic [3:0]           joint;
        logic signed [DW-1:0] cmd;
    } cmd_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [2:0]           cfg_index;
    logic [LIM_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           func;
    logic [3:0]           joint;
    logic signed [DW-1:0] position_ref;
    logic signed [DW-1:0] velocity_ref;
    logic signed [DW-1:0] position_meas;
    logic signed [DW-1:0] velocity_meas;
    logic [2:0]           gain_select;
    logic signed [DW-1:0] gain_value;
    logic                 out_valid;
    logic                 out_ready;
    logic [3:0]           joint_out;
    logic signed [DW-1:0] cmd_vel;

    cascade_pid_joint_velocity #(.JOINTS(NJ)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .joint         (joint),
        .position_ref  (position_ref),
        .velocity_ref  (velocity_ref),
        .position_meas (position_meas),
        .velocity_meas (velocity_meas),
        .gain_select   (gain_select),
        .gain_value    (gain_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .joint_out     (joint_out),
        .cmd_vel       (cmd_vel)
    );

    // Predictor copy of configuration and joint state
    logic [DT_W-1:0] period;
    longint          oi_lim, ii_lim, ov_lim, cv_lim, ca_lim;
    longint          pos_integ [NJ];
    longint          vel_integ [NJ];
    longint          prev_pos_err [NJ];
    longint          prev_vel_err [NJ];
    longint          held_cmd [NJ];
    longint          gains [NJ][GAINS];

    cmd_t   pending_cmds[$];
    int     err_cnt;
    int     step_cnt;
    int     result_cnt;
    int     item_cnt;
    bit     idle_on;
    bit     hold_req;
    int     hold_cnt;

    // Clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------------
    // Fixed-point helpers
    // ------------------------------------------------------------------------
    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint lim_mag(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // product shifted right n, rounding half up
    function automatic longint mul_rnd(longint a, longint b, int n);
        longint p;
        p = a * b + (longint'(1) <<< (n - 1));
        return p >>> n;
    endfunction

    function automatic longint deriv(longint diff, longint dt);
        return sat32((sat32(diff) * (longint'(1) <<< 24)) / dt);
    endfunction

    function automatic void clear_joint_state(int j);
        pos_integ[j]    = 0;
        vel_integ[j]    = 0;
        prev_pos_err[j] = 0;
        prev_vel_err[j] = 0;
        held_cmd[j]     = 0;
    endfunction

    // Apply one accepted beat to the predictor, queue a command if any
    function automatic void apply_beat(beat_t b);
        longint dt, pe, ve, d, vref, cmd, dvmax, delta;
        int     j;
        cmd_t   c;
        j = int'(b.joint);
        if (b.func == FUNC_RSTALL)
        begin
            for (int k = 0; k < NJ; k++)
                clear_joint_state(k);
            return;
        end
        if (b.func == FUNC_GAIN)
        begin
            if (b.gsel < GAINS)
                gains[j][b.gsel] = longint'(b.gval);
            return;
        end
        if (b.func == FUNC_RST)
        begin
            clear_joint_state(j);
            return;
        end
        dt = longint'(period);
        if (dt < longint'(DT_MIN))
            dt = longint'(DT_MIN);
        if (dt > longint'(DT_MAX))
            dt = longint'(DT_MAX);

        // position loop
        pe = sat32(longint'(b.pos_ref) - longint'(b.pos_meas));
        pos_integ[j] = lim_mag(sat32(pos_integ[j] + sat32(mul_rnd(pe, dt, 24))), oi_lim);
        d = deriv(pe - prev_pos_err[j], dt);
        vref = sat32(longint'(b.vel_ref)
                     + sat32(mul_rnd(gains[j][G_OKP], pe, 16))
                     + sat32(mul_rnd(gains[j][G_OKI], pos_integ[j], 16))
                     + sat32(mul_rnd(gains[j][G_OKD], d, 16)));
        vref = lim_mag(vref, ov_lim);

        // velocity loop
        ve = sat32(vref - longint'(b.vel_meas));
        vel_integ[j] = lim_mag(sat32(vel_integ[j] + sat32(mul_rnd(ve, dt, 24))), ii_lim);
        d = deriv(ve - prev_vel_err[j], dt);
        cmd = sat32(vref
                    + sat32(mul_rnd(gains[j][G_IKP], ve, 16))
                    + sat32(mul_rnd(gains[j][G_IKI], vel_integ[j], 16))
                    + sat32(mul_rnd(gains[j][G_IKD], d, 16)));

        // rate then magnitude limit
        dvmax = mul_rnd(ca_lim, dt, 24);
        delta = lim_mag(cmd - held_cmd[j], dvmax);
        cmd = sat32(held_cmd[j] + delta);
        cmd = lim_mag(cmd, cv_lim);

        prev_pos_err[j] = pe;
        prev_vel_err[j] = ve;
        held_cmd[j]     = cmd;
        c.joint = b.joint;
        c.cmd   = cmd[DW-1:0];
        pending_cmds.push_back(c);
        step_cnt++;
    endfunction

    // ------------------------------------------------------------------------
    // Channel tasks
    // ------------------------------------------------------------------------
    task automatic send_beat(beat_t b);
        while (idle_on && $urandom_range(99) < 38)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= b.func;
        joint         <= b.joint;
        position_ref  <= b.pos_ref;
        velocity_ref  <= b.vel_ref;
        position_meas <= b.pos_meas;
        velocity_meas <= b.vel_meas;
        gain_select   <= b.gsel;
        gain_value    <= b.gval;
        do
            @(posedge clk);
        while (!in_ready);
        apply_beat(b);
        item_cnt++;
    endtask

    // stop offering and wait until every command is back and the block settles
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [LIM_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_STEP_TIME: period = val[DT_W-1:0];
            REG_OI_LIM:    oi_lim = longint'(val);
            REG_II_LIM:    ii_lim = longint'(val);
            REG_OV_LIM:    ov_lim = longint'(val);
            REG_CV_LIM:    cv_lim = longint'(val);
            REG_CA_LIM:    ca_lim = longint'(val);
            default: ;
        endcase
    endtask

    task automatic write_all_regs(logic [DT_W-1:0] dt, logic [LIM_W-1:0] oil,
                                  logic [LIM_W-1:0] iil, logic [LIM_W-1:0] ovl,
                                  logic [LIM_W-1:0] cvl, logic [LIM_W-1:0] cal);
        write_reg(REG_STEP_TIME, LIM_W'(dt));
        write_reg(REG_OI_LIM, oil);
        write_reg(REG_II_LIM, iil);
        write_reg(REG_OV_LIM, ovl);
        write_reg(REG_CV_LIM, cvl);
        write_reg(REG_CA_LIM, cal);
    endtask

    // ------------------------------------------------------------------------
    // Beat builders
    // ------------------------------------------------------------------------
    function automatic logic signed [DW-1:0] pick_word();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return DW'($signed($urandom_range(2 * 65536 * 16)) - 65536 * 16);
        if (r < 90)
            return $urandom;
        if (r < 95)
            return 32'sh7fff_ffff;
        return 32'sh8000_0000;
    endfunction

    function automatic logic signed [DW-1:0] pick_gain();
        if ($urandom_range(9) < 8)
            return DW'($signed($urandom_range(8 * 65536)) - 4 * 65536);
        return $urandom;
    endfunction

    function automatic beat_t mk_step(logic [3:0] j, logic signed [DW-1:0] pr,
                                      logic signed [DW-1:0] vr, logic signed [DW-1:0] pm,
                                      logic signed [DW-1:0] vm);
        beat_t b;
        b.func = FUNC_STEP; b.joint = j;
        b.pos_ref = pr; b.vel_ref = vr; b.pos_meas = pm; b.vel_meas = vm;
        b.gsel = 3'($urandom); b.gval = $urandom;
        return b;
    endfunction

    function automatic beat_t mk_ctl(logic [1:0] f, logic [3:0] j, logic [2:0] sel,
                                     logic signed [DW-1:0] g);
        beat_t b;
        b = mk_step(j, $urandom, $urandom, $urandom, $urandom);
        b.func = f; b.gsel = sel; b.gval = g;
        return b;
    endfunction

    function automatic beat_t rand_step();
        return mk_step(4'($urandom), pick_word(), pick_word(), pick_word(), pick_word());
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed;
        // zero gains at reset: command follows feed-forward under limits
        send_beat(mk_step(4'd0, 32'sd0, 32'sd32768, 32'sd0, 32'sd0));
        send_beat(mk_step(4'd0, 32'sh7fff_ffff, 32'sh7fff_ffff,
                          32'sh8000_0000, 32'sh8000_0000));
        // all gain slots plus the two unused selects
        send_beat(mk_ctl(FUNC_GAIN, 4'd3, G_OKP, 32'sd65536));
        send_beat(mk_ctl(FUNC_GAIN, 4'd3, G_OKI, 32'sd32768));
        send_beat(mk_ctl(FUNC_GAIN, 4'd3, G_OKD, 32'sd1024));
        send_beat(mk_ctl(FUNC_GAIN, 4'd3, G_IKP, 32'sd131072));
        send_beat(mk_ctl(FUNC_GAIN, 4'd3, G_IKI, 32'sd16384));
        send_beat(mk_ctl(FUNC_GAIN, 4'd3, G_IKD, 32'sd512));
        send_beat(mk_ctl(FUNC_GAIN, 4'd3, 3'd6, 32'sh7fff_ffff));
        send_beat(mk_ctl(FUNC_GAIN, 4'd3, 3'd7, 32'sh8000_0000));
        send_beat(mk_step(4'd3, 32'sd65536, 32'sd0, 32'sd0, 32'sd0));
        send_beat(mk_step(4'd3, 32'sd65536, 32'sd0, 32'sd16384, 32'sd1000));
        send_beat(mk_step(4'd3, 32'sh8000_0000, 32'sh8000_0000,
                          32'sh7fff_ffff, 32'sh7fff_ffff));
        // extreme gains on the top joint
        send_beat(mk_ctl(FUNC_GAIN, 4'd15, G_OKP, 32'sh7fff_ffff));
        send_beat(mk_ctl(FUNC_GAIN, 4'd15, G_IKD, 32'sh8000_0000));
        send_beat(mk_step(4'd15, 32'sh7fff_ffff, 32'sd0, 32'sh8000_0000, 32'sd0));
        // joint reset keeps gains, reset-all clears every joint
        send_beat(mk_ctl(FUNC_RST, 4'd3, 3'd0, 32'sd0));
        send_beat(mk_step(4'd3, 32'sd65536, 32'sd0, 32'sd0, 32'sd0));
        send_beat(mk_ctl(FUNC_RSTALL, 4'd9, 3'd0, 32'sd0));
        send_beat(mk_step(4'd15, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
        send_beat(mk_step(4'd3, 32'sd65536, 32'sd0, 32'sd0, 32'sd0));
        drain();
    endtask

    // register extremes, period below and above its clamp range
    task automatic test_config_extremes;
        write_all_regs(22'd0, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff,
                       31'h7fff_ffff, 31'h7fff_ffff);
        repeat (6) send_beat(rand_step());
        drain();
        write_all_regs(22'h3f_ffff, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0);
        repeat (6) send_beat(rand_step());
        drain();
        write_all_regs(DT_MIN, 31'd1, 31'h7fff_ffff, 31'd1, 31'h7fff_ffff, 31'd1);
        repeat (4) send_beat(rand_step());
        drain();
        write_all_regs(DT_MAX, 31'd524288, 31'd524288, 31'd1048576,
                       31'd1048576, 31'd6553600);
        repeat (4) send_beat(rand_step());
        drain();
    endtask

    // mostly steps on random joints, some gain loads, resets and noise
    task automatic run_random(int n);
        beat_t b;
        int    r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 64)
                b = rand_step();
            else if (r < 84)
                b = mk_ctl(FUNC_GAIN, 4'($urandom), 3'($urandom_range(7)), pick_gain());
            else if (r < 94)
                b = mk_ctl(FUNC_RST, 4'($urandom), 3'($urandom), $urandom);
            else
                b = mk_ctl(FUNC_RSTALL, 4'($urandom), 3'($urandom), $urandom);
            send_beat(b);
        end
    endtask

    task automatic test_random;
        for (int ph = 0; ph < 5; ph++)
        begin
            write_all_regs(DT_W'($urandom_range(DT_MAX + 20000, 1000)),
                           LIM_W'($urandom_range(65536 * 64)),
                           LIM_W'($urandom_range(65536 * 64)),
                           LIM_W'($urandom_range(65536 * 256)),
                           LIM_W'($urandom_range(65536 * 256)),
                           (ph == 4) ? 31'h7fff_ffff : 31'($urandom));
            // one phase runs with no idling on either side
            idle_on = (ph != 2);
            run_random(140);
            drain();
        end
        idle_on = 1'b1;
    endtask

    // receiver stalls while the sender keeps offering steps
    task automatic test_backpressure;
        hold_req = 1'b1;
        repeat (8) send_beat(rand_step());
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random ready with an occasional long hold-off
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= !(idle_on && $urandom_range(99) < 38);
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        err_cnt++;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        cmd_t c;
        if (rst_n && out_valid && out_ready)
        begin
            result_cnt++;
            if (pending_cmds.size() == 0)
                report_mismatch("unexpected beat, joint_out", longint'(joint_out), -1);
            else
            begin
                c = pending_cmds.pop_front();
                if (joint_out !== c.joint)
                    report_mismatch("joint_out", longint'(joint_out), longint'(c.joint));
                if (cmd_vel !== c.cmd)
                    report_mismatch("cmd_vel", longint'(cmd_vel), longint'(c.cmd));
            end
        end
    end

    // Watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        int quiet;
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT)
        begin
            $display("Watchdog expired with %0d results outstanding", pending_cmds.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; func = '0; joint = '0;
        position_ref = '0; velocity_ref = '0; position_meas = '0; velocity_meas = '0;
        gain_select = '0; gain_value = '0;
        out_ready = 1'b0;
        idle_on = 1'b1; hold_req = 1'b0; hold_cnt = 0;
        err_cnt = 0; step_cnt = 0; result_cnt = 0; item_cnt = 0;
        period = 22'd16777;
        oi_lim = 65536; ii_lim = 65536; ov_lim = 65536; cv_lim = 65536; ca_lim = 65536;
        for (int j = 0; j < NJ; j++)
        begin
            clear_joint_state(j);
            for (int g = 0; g < GAINS; g++)
                gains[j][g] = 0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random();

        drain();
        $display("Sent %0d beats, %0d control steps; %0d commands checked.",
                 item_cnt, step_cnt, result_cnt);
        $display("Covered gain loads, joint and global resets, register extremes, stalls.");
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[cascade_pid_joint_velocity.f]
rtl/cpjv_pkg.sv
rtl/cascade_pid_joint_velocity.sv
rtl/cpjv_checker.sv
test/tb.sv
